[hw/rtl/lc3_pkg.sv]
`timescale 1ns / 1ps
package lc3_pkg;
   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;

   localparam logic [1:0] FUNC_EXEC  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_RTI  = 4'd8;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_MUL  = 4'd13;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] access_addr;
      logic [15:0] access_data;
   } req_type;

   typedef struct packed {
      logic [15:0] exec_pc;
      logic [15:0] instr_word;
      logic [15:0] next_pc;
      logic        gpr_we;
      logic [2:0]  gpr_index;
      logic [15:0] gpr_value;
      logic        mem_we;
      logic [15:0] store_addr;
      logic [15:0] store_value;
      logic [15:0] psr_value;
      logic [15:0] read_data;
      logic        fault;
   } rsp_type;

   // Memory port address select.
   typedef enum logic [2:0] {
      ASEL_CLEAR  = 3'b001,
      ASEL_ACCESS = 3'b010,
      ASEL_DP     = 3'b100
   } asel_type;

   typedef struct packed {
      logic       clear_we;
      logic       access_rd;
      logic       access_wr;
      logic       fetch;    // read at PC
      logic       decode;   // latch instruction, form first address
      logic       rd1;      // read at first address
      logic       cap1;     // capture first read data, form second address
      logic       rd2;      // read at second address
      logic       finish;   // compute and commit
      logic       cap2;     // capture second read data
      logic       rsp_load_access;
   } cmd_type;

   typedef struct packed {
      logic need_rd1;
      logic need_rd2;
   } sts_type;

   function automatic logic [2:0] cc_of(input logic [15:0] r);
      if (r[15]) return 3'b100;
      else if (r == 16'h0000) return 3'b010;
      else return 3'b001;
   endfunction
endpackage

[hw/rtl/lc3_if.sv]
`timescale 1ns / 1ps
interface lc3_req_if;
   import lc3_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lc3_rsp_if;
   import lc3_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/lc3_ctrl.sv]
`timescale 1ns / 1ps
module lc3_ctrl import lc3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic [1:0] req_func,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    clearing
);
   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_FETCH  = 9'b000000100,
      ST_DECODE = 9'b000001000,
      ST_RD1    = 9'b000010000,
      ST_CAP1   = 9'b000100000,
      ST_RD2    = 9'b001000000,
      ST_FINISH = 9'b010000000,
      ST_ACCESS = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [MEM_ADDR_BITS:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign clearing  = (state_ff == ST_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (MEM_ADDR_BITS + 1)'(MEM_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               if (req_func == FUNC_EXEC) begin
                  cmd.fetch = 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  cmd.access_rd = (req_func == FUNC_READ);
                  cmd.access_wr = (req_func == FUNC_WRITE);
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            cmd.rsp_load_access = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FETCH: begin
            cmd.decode = 1'b1;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.need_rd1) begin
               cmd.rd1 = 1'b1;
               state_in = ST_RD1;
            end else begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_RD1: begin
            cmd.cap1 = 1'b1;
            state_in = ST_CAP1;
         end
         ST_CAP1: begin
            if (sts.need_rd2) begin
               cmd.rd2 = 1'b1;
               state_in = ST_RD2;
            end else begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_RD2: begin
            cmd.cap2 = 1'b1;
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result register is only reloaded once the previous item has gone.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.rsp_load_access) |-> out_free)
      else $error("result overwritten before it was taken");
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("item accepted during memory clear");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fetch, cmd.rd1, cmd.rd2, cmd.access_rd, cmd.access_wr, cmd.clear_we}))
      else $error("two memory commands in one cycle");
endmodule

[hw/rtl/lc3_dp.sv]
`timescale 1ns / 1ps
module lc3_dp import lc3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  logic    req_take,
   input  cmd_type cmd,
   input  logic    clearing,
   output sts_type sts,
   output rsp_type rsp
);
   logic [15:0] mem [MEM_WORDS];
   logic [MEM_ADDR_BITS-1:0] clr_addr_ff;
   logic [15:0] rdata_ff;

   logic [15:0] gpr_ff [8];
   logic [15:0] pc_ff, psr_ff;
   logic [15:0] ir_ff, addr1_ff, addr2_ff, d1_ff;
   logic [1:0]  acc_func_ff;
   rsp_type     rsp_ff;

   logic [MEM_ADDR_BITS-1:0] rd_addr;
   logic        mem_we;
   logic [MEM_ADDR_BITS-1:0] wr_addr;
   logic [15:0] wr_data;

   logic [3:0]  op;
   logic [15:0] ir, sx5, sx6, sx9, sx11, a, b, npc;
   logic [15:0] first_addr;
   logic        need1, need2;
   logic [15:0] prod;

   assign ir   = ir_ff;
   assign op   = ir[15:12];
   assign sx5  = {{11{ir[4]}}, ir[4:0]};
   assign sx6  = {{10{ir[5]}}, ir[5:0]};
   assign sx9  = {{7{ir[8]}}, ir[8:0]};
   assign sx11 = {{5{ir[10]}}, ir[10:0]};
   assign a    = gpr_ff[ir[8:6]];
   assign npc  = pc_ff + 16'd1;
   // The low half of the product is the same for signed and unsigned operands.
   assign prod = a * b;

   // In decode the instruction word arrives from memory, so decode works on rdata.
   logic [15:0] dw;
   logic [3:0]  dop;
   assign dw  = rdata_ff;
   assign dop = dw[15:12];
   always_comb begin
      need1 = 1'b0;
      need2 = 1'b0;
      first_addr = '0;
      unique case (dop)
         OP_LD, OP_LDI, OP_STI: begin
            need1 = 1'b1;
            first_addr = npc + {{7{dw[8]}}, dw[8:0]};
         end
         OP_LDR: begin
            need1 = 1'b1;
            first_addr = gpr_ff[dw[8:6]] + {{10{dw[5]}}, dw[5:0]};
         end
         OP_RTI: begin
            need1 = !psr_ff[15];
            need2 = !psr_ff[15];
            first_addr = gpr_ff[6];
         end
         OP_TRAP: begin
            need1 = (dw[11:8] == 4'd0);
            first_addr = {8'd0, dw[7:0]};
         end
         default: ;
      endcase
      if (dop == OP_LDI) need2 = 1'b1;
   end
   // Decisions are held after decode; the second read only follows the first.
   logic need2_ff;
   assign sts.need_rd1 = need1;
   assign sts.need_rd2 = need2_ff;

   always_comb begin
      rd_addr = pc_ff[MEM_ADDR_BITS-1:0];
      if (cmd.access_rd) rd_addr = req.access_addr[MEM_ADDR_BITS-1:0];
      else if (cmd.rd1) rd_addr = first_addr[MEM_ADDR_BITS-1:0];
      else if (cmd.rd2) rd_addr = addr2_ff[MEM_ADDR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (mem_we) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else if (clearing) clr_addr_ff <= clr_addr_ff + 1'b1;
      else clr_addr_ff <= '0;
   end

   // Execute stage: combinational result from held operands.
   logic        we, mwe, flt, setcc;
   logic [2:0]  widx;
   logic [15:0] wval, saddr, sval, npc_o, psr_o, d2;
   assign d2 = cmd.cap2 ? rdata_ff : d1_ff;

   always_comb begin
      b = ir[5] ? sx5 : gpr_ff[ir[2:0]];
      we = 1'b0; mwe = 1'b0; flt = 1'b0; setcc = 1'b0;
      widx = ir[11:9]; wval = '0; saddr = '0; sval = gpr_ff[ir[11:9]];
      npc_o = npc; psr_o = psr_ff;
      unique case (op)
         OP_ADD: begin
            if (ir[5]) wval = a + sx5;
            else if (ir[4]) wval = a - gpr_ff[ir[2:0]];
            else wval = a + gpr_ff[ir[2:0]];
            if (!ir[5] && ir[3]) flt = 1'b1;
            else begin we = 1'b1; setcc = 1'b1; end
         end
         OP_AND, OP_MUL: begin
            wval = (op == OP_AND) ? (a & b) : prod;
            if (ir[5] || ir[4:3] == 2'b00) begin we = 1'b1; setcc = 1'b1; end
         end
         OP_NOT: begin
            wval = ~a;
            if (ir[5:0] == 6'h3F) begin we = 1'b1; setcc = 1'b1; end
         end
         OP_BR: begin
            if ((ir[11] && psr_ff[2:0] == 3'b100) || (ir[10] && psr_ff[2:0] == 3'b010) ||
                (ir[9] && psr_ff[2:0] == 3'b001))
               npc_o = npc + sx9;
         end
         OP_JMP: begin
            if (ir[0]) psr_o = psr_ff & 16'h7FFF;
            if ((ir & 16'h0E3E) != 16'd0) flt = 1'b1;
            else npc_o = a;
         end
         OP_JSR: begin
            if (ir[11] || (ir & 16'h063F) == 16'd0) begin
               we = 1'b1; widx = 3'd7; wval = npc;
               npc_o = ir[11] ? npc + sx11 : a;
            end
         end
         OP_LD, OP_LDR, OP_LDI: begin
            we = 1'b1; setcc = 1'b1; wval = d2;
         end
         OP_LEA: begin
            we = 1'b1; setcc = 1'b1; wval = npc + sx9;
         end
         OP_RTI: begin
            if (!psr_ff[15]) begin
               npc_o = d1_ff; psr_o = d2;
               we = 1'b1; widx = 3'd6; wval = gpr_ff[6] + 16'd2;
            end
         end
         OP_ST: begin mwe = 1'b1; saddr = npc + sx9; end
         OP_STI: begin mwe = 1'b1; saddr = d1_ff; end
         OP_STR: begin mwe = 1'b1; saddr = a + sx6; end
         OP_TRAP: begin
            if (ir[11:8] != 4'd0) flt = 1'b1;
            else begin
               we = 1'b1; widx = 3'd7; wval = npc;
               psr_o = psr_ff | 16'h8000; npc_o = d1_ff;
            end
         end
         default: ;
      endcase
      if (setcc) psr_o = {psr_o[15:3], cc_of(wval)};
      if (!we) begin widx = '0; wval = '0; end
      if (!mwe) begin saddr = '0; sval = '0; end
   end

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = addr1_ff[MEM_ADDR_BITS-1:0];
      wr_data = sval;
      if (clearing) begin
         mem_we = 1'b1; wr_addr = clr_addr_ff; wr_data = '0;
      end else if (cmd.access_wr) begin
         mem_we = 1'b1; wr_addr = req.access_addr[MEM_ADDR_BITS-1:0];
         wr_data = req.access_data;
      end else if (cmd.finish && mwe) begin
         mem_we = 1'b1; wr_addr = saddr[MEM_ADDR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) acc_func_ff <= req.func;
      if (cmd.decode) begin
         ir_ff    <= rdata_ff;
         addr1_ff <= first_addr;
         need2_ff <= need2;
      end
      if (cmd.cap1) begin
         d1_ff    <= rdata_ff;
         addr2_ff <= (ir_ff[15:12] == OP_RTI) ? addr1_ff + 16'd1 : rdata_ff;
      end
      if (clearing) begin
         for (int i = 0; i < 8; i++) gpr_ff[i] <= '0;
         pc_ff  <= '0;
         psr_ff <= '0;
      end else if (cmd.finish) begin
         if (we) gpr_ff[widx] <= wval;
         pc_ff  <= npc_o;
         psr_ff <= psr_o;
      end
      if (cmd.finish) begin
         rsp_ff.exec_pc     <= pc_ff;
         rsp_ff.instr_word  <= ir_ff;
         rsp_ff.next_pc     <= npc_o;
         rsp_ff.gpr_we      <= we;
         rsp_ff.gpr_index   <= widx;
         rsp_ff.gpr_value   <= wval;
         rsp_ff.mem_we      <= mwe;
         rsp_ff.store_addr  <= saddr;
         rsp_ff.store_value <= sval;
         rsp_ff.psr_value   <= psr_o;
         rsp_ff.read_data   <= '0;
         rsp_ff.fault       <= flt;
      end else if (cmd.rsp_load_access) begin
         rsp_ff.exec_pc     <= '0;
         rsp_ff.instr_word  <= '0;
         rsp_ff.next_pc     <= pc_ff;
         rsp_ff.gpr_we      <= 1'b0;
         rsp_ff.gpr_index   <= '0;
         rsp_ff.gpr_value   <= '0;
         rsp_ff.mem_we      <= 1'b0;
         rsp_ff.store_addr  <= '0;
         rsp_ff.store_value <= '0;
         rsp_ff.psr_value   <= psr_ff;
         rsp_ff.read_data   <= (acc_func_ff == FUNC_READ) ? rdata_ff : 16'd0;
         rsp_ff.fault       <= 1'b0;
      end
   end

   assign rsp = rsp_ff;
endmodule

[hw/rtl/lc3_instruction_step.sv]
`timescale 1ns / 1ps
// Steps: a write or read item passes through an access state; an execute item passes
// through fetch, decode, up to two memory reads for LDI and RTI, then commit.
// One item is handled at a time: a new item is accepted only in idle and once the previous
// result has been taken or is being taken. All steps read memory through one shared read port.
// Reset: synchronous; afterwards a clearing pass zeroes every memory word and
// the registers, during which no item is accepted.
module lc3_instruction_step import lc3_pkg::*; (
   input logic clock,
   input logic reset,
   lc3_req_if.sink   req,
   lc3_rsp_if.source rsp
);
   cmd_type cmd;
   sts_type sts;
   logic    clearing;
   logic    req_ready;

   assign req.ready = req_ready;

   lc3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_func  (req.data.func),
      .req_ready (req_ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd),
      .clearing  (clearing)
   );

   lc3_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req      (req.data),
      .req_take (req.valid && req_ready),
      .cmd      (cmd),
      .clearing (clearing),
      .sts      (sts),
      .rsp      (rsp.data)
   );
endmodule

[tb/tb_lc3_instruction_step.sv]
`timescale 1ns / 1ps
module tb_lc3_instruction_step;
   import lc3_pkg::*;

   class lc3_scoreboard;
      logic [15:0] regs [8];
      logic [15:0] pc;
      logic [15:0] psr;
      logic [15:0] mem [int];
      rsp_type pending [$];
      int errors;

      function new();
         for (int i = 0; i < 8; i++) regs[i] = '0;
         pc = '0;
         psr = '0;
         errors = 0;
      endfunction

      function logic [15:0] rd(input logic [15:0] a);
         if (mem.exists(a)) return mem[a];
         return '0;
      endfunction

      function logic [15:0] sext(input logic [15:0] w, input int bits);
         logic [15:0] v;
         logic [15:0] m;
         m = (16'd1 << bits) - 16'd1;
         v = w & m;
         if (v[bits-1]) v = v | ~m;
         return v;
      endfunction

      function logic [2:0] flags(input logic [15:0] r);
         if (r[15]) return 3'b100;
         if (r == 16'h0000) return 3'b010;
         return 3'b001;
      endfunction

      function void note_request(input req_type q);
         rsp_type e;
         logic [15:0] w, npc, a, b, r, t;
         logic [2:0] dr, sr1, sr2;
         logic ok, setcc;
         e = '0;
         ok = 1'b1;
         setcc = 1'b0;
         b = '0;
         r = '0;
         if (q.func == FUNC_WRITE) begin
            mem[q.access_addr] = q.access_data;
         end else if (q.func == FUNC_READ) begin
            e.read_data = rd(q.access_addr);
         end else if (q.func == FUNC_EXEC) begin
            w = rd(pc);
            e.exec_pc = pc;
            e.instr_word = w;
            npc = pc + 16'd1;
            dr = w[11:9];
            sr1 = w[8:6];
            sr2 = w[2:0];
            a = regs[sr1];
            case (w[15:12])
               OP_ADD: begin
                  if (w[5]) r = a + sext(w, 5);
                  else if (w[3]) begin
                     e.fault = 1'b1;
                     ok = 1'b0;
                  end else if (w[4]) r = a - regs[sr2];
                  else r = a + regs[sr2];
                  if (ok) begin
                     e.gpr_we = 1'b1; e.gpr_index = dr; e.gpr_value = r; setcc = 1'b1;
                  end
               end
               OP_AND, OP_MUL: begin
                  if (w[5]) b = sext(w, 5);
                  else if (w[4] || w[3]) ok = 1'b0;
                  else b = regs[sr2];
                  if (ok) begin
                     r = (w[15:12] == OP_AND) ? (a & b) : 16'(a * b);
                     e.gpr_we = 1'b1; e.gpr_index = dr; e.gpr_value = r; setcc = 1'b1;
                  end
               end
               OP_NOT: begin
                  if (w[5:0] == 6'h3F) begin
                     e.gpr_we = 1'b1; e.gpr_index = dr; e.gpr_value = ~a; setcc = 1'b1;
                  end
               end
               OP_BR: begin
                  if ((w[11] && psr[2:0] == 3'b100) || (w[10] && psr[2:0] == 3'b010) ||
                      (w[9] && psr[2:0] == 3'b001))
                     npc = npc + sext(w, 9);
               end
               OP_JMP: begin
                  if (w[0]) psr[15] = 1'b0;
                  if ((w & 16'h0E3E) != 16'd0) e.fault = 1'b1;
                  else npc = a;
               end
               OP_JSR: begin
                  if (w[11] || (w & 16'h063F) == 16'd0) begin
                     t = w[11] ? npc + sext(w, 11) : a;
                     e.gpr_we = 1'b1; e.gpr_index = 3'd7; e.gpr_value = npc;
                     npc = t;
                  end
               end
               OP_LD: begin
                  e.gpr_we = 1'b1; e.gpr_index = dr; e.gpr_value = rd(npc + sext(w, 9));
                  setcc = 1'b1;
               end
               OP_LDI: begin
                  e.gpr_we = 1'b1; e.gpr_index = dr;
                  e.gpr_value = rd(rd(npc + sext(w, 9)));
                  setcc = 1'b1;
               end
               OP_LDR: begin
                  e.gpr_we = 1'b1; e.gpr_index = dr; e.gpr_value = rd(a + sext(w, 6));
                  setcc = 1'b1;
               end
               OP_LEA: begin
                  e.gpr_we = 1'b1; e.gpr_index = dr; e.gpr_value = npc + sext(w, 9);
                  setcc = 1'b1;
               end
               OP_RTI: begin
                  if (!psr[15]) begin
                     t = regs[6];
                     npc = rd(t);
                     psr = rd(t + 16'd1);
                     e.gpr_we = 1'b1; e.gpr_index = 3'd6; e.gpr_value = t + 16'd2;
                  end
               end
               OP_ST: begin
                  e.mem_we = 1'b1; e.store_addr = npc + sext(w, 9); e.store_value = regs[dr];
               end
               OP_STI: begin
                  e.mem_we = 1'b1; e.store_addr = rd(npc + sext(w, 9));
                  e.store_value = regs[dr];
               end
               OP_STR: begin
                  e.mem_we = 1'b1; e.store_addr = a + sext(w, 6); e.store_value = regs[dr];
               end
               default: begin
                  if (w[11:8] != 4'd0) e.fault = 1'b1;
                  else begin
                     e.gpr_we = 1'b1; e.gpr_index = 3'd7; e.gpr_value = npc;
                     psr[15] = 1'b1;
                     npc = rd({8'h00, w[7:0]});
                  end
               end
            endcase
            if (e.gpr_we) regs[e.gpr_index] = e.gpr_value;
            if (setcc) psr[2:0] = flags(e.gpr_value);
            if (e.mem_we) mem[e.store_addr] = e.store_value;
            pc = npc;
         end
         e.next_pc = pc;
         e.psr_value = psr;
         pending.push_back(e);
      endfunction

      function void check_response(input rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response item %h", g);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.exec_pc !== e.exec_pc) begin
            $error("exec_pc exp %h got %h", e.exec_pc, g.exec_pc); errors++;
         end
         if (g.instr_word !== e.instr_word) begin
            $error("instr_word exp %h got %h", e.instr_word, g.instr_word); errors++;
         end
         if (g.next_pc !== e.next_pc) begin
            $error("next_pc exp %h got %h", e.next_pc, g.next_pc); errors++;
         end
         if (g.gpr_we !== e.gpr_we) begin
            $error("gpr_we exp %h got %h", e.gpr_we, g.gpr_we); errors++;
         end
         if (g.gpr_index !== e.gpr_index) begin
            $error("gpr_index exp %h got %h", e.gpr_index, g.gpr_index); errors++;
         end
         if (g.gpr_value !== e.gpr_value) begin
            $error("gpr_value exp %h got %h", e.gpr_value, g.gpr_value); errors++;
         end
         if (g.mem_we !== e.mem_we) begin
            $error("mem_we exp %h got %h", e.mem_we, g.mem_we); errors++;
         end
         if (g.store_addr !== e.store_addr) begin
            $error("store_addr exp %h got %h", e.store_addr, g.store_addr); errors++;
         end
         if (g.store_value !== e.store_value) begin
            $error("store_value exp %h got %h", e.store_value, g.store_value); errors++;
         end
         if (g.psr_value !== e.psr_value) begin
            $error("psr_value exp %h got %h", e.psr_value, g.psr_value); errors++;
         end
         if (g.read_data !== e.read_data) begin
            $error("read_data exp %h got %h", e.read_data, g.read_data); errors++;
         end
         if (g.fault !== e.fault) begin
            $error("fault exp %h got %h", e.fault, g.fault); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   lc3_req_if req ();
   lc3_rsp_if rsp ();

   lc3_instruction_step dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #4 clock = ~clock;

   lc3_scoreboard board;
   int send_idle = 7;
   int recv_idle = 88;
   int hold_cycles = 0;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // Responses are sampled on each rising edge, where ready is also redrawn unless a hold keeps it low.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) board.check_response(rsp.data);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Valid stays high after an accepted item so that items can follow back to back.
   task automatic send_item(input logic [1:0] f, input logic [15:0] ad, input logic [15:0] dt);
      req_type q;
      q.func = f;
      q.access_addr = ad;
      q.access_data = dt;
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= q;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(q);
   endtask

   // Loads a word at the PC and executes it; the executed instruction is steered by writing memory.
   task automatic run_word(input logic [15:0] w);
      send_item(FUNC_WRITE, board.pc, w);
      send_item(FUNC_EXEC, 16'($urandom), 16'($urandom));
   endtask

   function automatic logic [15:0] random_word();
      logic [15:0] w;
      w = 16'($urandom);
      case ($urandom_range(5))
         0: w[5] = 1'b1;
         1: if (w[15:12] == OP_JMP) w = w & ~16'h0E3E;
         2: if (w[15:12] == OP_TRAP) w[11:8] = 4'h0;
         3: if (w[15:12] == OP_NOT) w[5:0] = 6'h3F;
         4: if (w[15:12] == OP_JSR && !w[11]) w = w & ~16'h063F;
         default: ;
      endcase
      return w;
   endfunction

   task automatic random_phase(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0: send_item(FUNC_WRITE, 16'($urandom), 16'($urandom));
            1: send_item(FUNC_READ, 16'($urandom), 16'h0);
            2: send_item(FUNC_SPARE, 16'($urandom), 16'($urandom));
            3: send_item(FUNC_WRITE, 16'($urandom_range(16'h00FF)), 16'($urandom));
            4: send_item(FUNC_EXEC, 16'($urandom), 16'($urandom));
            default: run_word(random_word());
         endcase
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Directed: every opcode plus the faulting and no-op encodings.
      send_item(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
      send_item(FUNC_READ, 16'hFFFF, 16'h0);
      send_item(FUNC_READ, 16'h0000, 16'h0);
      send_item(FUNC_EXEC, 16'h0, 16'h0);
      run_word(16'h1021);   // ADD R0,R0,#1
      run_word(16'h127F);   // ADD R1,R1,#-1
      run_word(16'h1408);   // ADD register form with bit 3: fault
      run_word(16'h1650);   // SUB
      run_word(16'hD23F);   // MUL by -1
      run_word(16'h5218);   // AND with bits 4..3 set: no-op
      run_word(16'h967F);   // NOT
      run_word(16'h9601);   // malformed NOT
      run_word(16'h0E01);   // BR nzp
      run_word(16'h2DFF);   // LD
      run_word(16'hA1FE);   // LDI
      run_word(16'h6C7F);   // LDR
      run_word(16'hEFFF);   // LEA
      run_word(16'h3FFF);   // ST
      run_word(16'hB1FE);   // STI
      run_word(16'h7E3F);   // STR
      run_word(16'h4801);   // JSR
      run_word(16'h4601);   // malformed JSRR
      run_word(16'hF025);   // TRAP
      run_word(16'hF125);   // TRAP with bits 11..8: fault
      run_word(16'h8000);   // RTI while privileged: no-op
      run_word(16'hC003);   // RTT faulting, privilege still cleared
      run_word(16'h8000);   // RTI unprivileged
      run_word(16'hC1C0);   // RET
      random_phase(110);
      send_idle = 88;
      recv_idle = 7;
      random_phase(100);
      send_idle = 0;
      recv_idle = 0;
      hold_cycles = 300;
      random_phase(110);
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[sim.f]
hw/rtl/lc3_pkg.sv
hw/rtl/lc3_if.sv
hw/rtl/lc3_ctrl.sv
hw/rtl/lc3_dp.sv
hw/rtl/lc3_instruction_step.sv
tb/tb_lc3_instruction_step.sv
